[rtl/knc_pkg.sv]
// Shared constants and types for the k-center novelty cache.
`timescale 1ns / 1ps
`default_nettype none
package knc_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_DIM        = 3;

    localparam int STAMP_W    = 48;
    localparam int OCC_W      = 11;
    localparam int DIM_W      = 2;
    localparam int CAP_W      = 11;
    localparam int EPS_W      = 16;
    localparam int EPS2_W     = 2 * EPS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 2'd2;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd819;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } knc_state_t;

    // which coordinates take part in the distance
    typedef struct packed {
        logic use_y;
        logic use_z;
    } knc_lanes_t;

endpackage
`default_nettype wire

[rtl/knc_if.sv]
// Handshake channels: point input, result output, configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface knc_point_if #(
    parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface knc_result_if;
    logic                      valid;
    logic                      ready;
    logic                      novel;
    logic                      evicted;
    logic [knc_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, output novel, output evicted, output occupancy,
                    input ready);
    modport sink   (input valid, input novel, input evicted, input occupancy,
                    output ready);
endinterface

interface knc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [knc_pkg::CFG_IDX_W-1:0]  index;
    logic [knc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/knc_store.sv]
// Center memory: coordinates and insert stamp per slot, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none
module knc_store #(
    parameter int CAPACITY   = knc_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF,
    parameter int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic                              rd_valid,
    output logic [AW-1:0]                     rd_idx,
    output logic [3*COORD_BITS-1:0]           rd_coords,
    output logic [knc_pkg::STAMP_W-1:0]       rd_stamp,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [3*COORD_BITS-1:0]      wr_coords,
    input  wire logic [knc_pkg::STAMP_W-1:0]  wr_stamp
);

    logic [3*COORD_BITS-1:0]     coord_mem [CAPACITY];
    logic [knc_pkg::STAMP_W-1:0] stamp_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem[wr_addr] <= wr_coords;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_coords <= coord_mem[rd_addr];
            rd_stamp  <= stamp_mem[rd_addr];
            rd_idx    <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid <= 1'b0;
        else
            rd_valid <= rd_en;
    end

endmodule
`default_nettype wire

[rtl/knc_dist.sv]
// Shared squared-distance unit: per-axis squares, then sum, one center per cycle.
`timescale 1ns / 1ps
`default_nettype none
module knc_dist #(
    parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF,
    parameter int AW         = 10,
    parameter int DW         = 2 * (COORD_BITS + 1) + 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire knc_pkg::knc_lanes_t          lanes,
    input  wire logic [3*COORD_BITS-1:0]      point,
    input  wire logic [knc_pkg::STAMP_W-1:0]  stamp_now,
    input  wire logic                         in_valid,
    input  wire logic [AW-1:0]                in_idx,
    input  wire logic [3*COORD_BITS-1:0]      in_coords,
    input  wire logic [knc_pkg::STAMP_W-1:0]  in_stamp,
    output logic                              busy,
    output logic                              dist_valid,
    output logic [DW-1:0]                     dist_sum,
    output logic [knc_pkg::STAMP_W-1:0]       age,
    output logic [AW-1:0]                     idx
);

    localparam int SQW = 2 * (COORD_BITS + 1);

    logic signed [COORD_BITS:0]  diff [3];
    logic signed [SQW-1:0]       sq   [3];
    logic [SQW-1:0]              sq_reg [3];
    logic [knc_pkg::STAMP_W-1:0] age_reg;
    logic [AW-1:0]               idx_reg;
    logic                        sq_valid_reg;
    logic [2:0]                  lane_on;

    assign lane_on = {lanes.use_z, lanes.use_y, 1'b1};

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = $signed({point[a*COORD_BITS + COORD_BITS-1],
                               point[a*COORD_BITS +: COORD_BITS]})
                    - $signed({in_coords[a*COORD_BITS + COORD_BITS-1],
                               in_coords[a*COORD_BITS +: COORD_BITS]});
            if (lane_on[a])
                sq[a] = diff[a] * diff[a];
            else
                sq[a] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int a = 0; a < 3; a++)
                sq_reg[a] <= $unsigned(sq[a]);
            // modular age: smaller means more recently inserted
            age_reg <= stamp_now - in_stamp;
            idx_reg <= in_idx;
        end
        if (sq_valid_reg)
        begin
            dist_sum <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            age      <= age_reg;
            idx      <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            dist_valid   <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= in_valid;
            dist_valid   <= sq_valid_reg;
        end
    end

    assign busy = in_valid | sq_valid_reg | dist_valid;

endmodule
`default_nettype wire

[rtl/kcenter_novelty_cache_top.sv]
// Top level of the k-center novelty cache: sequencer, config registers, scan bookkeeping.
//
// Usage:
//   point_in   : one point per beat (coord_x/y/z, signed Q2.14).
//   result_out : one result beat per point: novel, evicted, occupancy.
//   cfg        : register writes (0 dimension, 1 capacity, 2 epsilon); always ready.
//                Write only while no point is in flight.
// Scan:
//   Each point scans the store: one stored center is read per cycle on the
//   single memory read port and fed through the shared squared-distance unit,
//   and the sequencer finds both the epsilon hit and the nearest center
//   (ties go to the most recent insert). No new point is taken until the
//   result of the last one is decided.
// Output stall:
//   The result sits in an output register; a new point is taken while it waits.
//   A second result waits in the decide step until the register frees.
// Reset:
//   Occupancy and insert counter clear, registers take their reset values.
//   The store itself is not cleared; only occupied slots are ever read.
`timescale 1ns / 1ps
`default_nettype none
module kcenter_novelty_cache_top #(
    parameter int CAPACITY   = knc_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = knc_pkg::COORD_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    knc_point_if.sink   point_in,
    knc_result_if.source result_out,
    knc_cfg_if.sink     cfg
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = CW + knc_pkg::CAP_W;
    localparam int DW  = 2 * (COORD_BITS + 1) + 2;
    localparam int CMW = DW + knc_pkg::EPS2_W;
    localparam int OW  = knc_pkg::OCC_W;
    localparam int SW  = knc_pkg::STAMP_W;

    knc_pkg::knc_state_t state_reg, state_next;

    logic [knc_pkg::DIM_W-1:0] dim_reg;
    logic [knc_pkg::CAP_W-1:0] cap_reg;
    logic [knc_pkg::EPS_W-1:0] eps_reg;
    logic [knc_pkg::EPS2_W-1:0] eps2_reg;

    logic [3*COORD_BITS-1:0] pt_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           scan_idx_reg;
    logic [SW-1:0]           ctr_reg;

    logic                    hit_reg;
    logic                    best_valid_reg;
    logic [DW-1:0]           best_dist_reg;
    logic [SW-1:0]           best_age_reg;
    logic [AW-1:0]           best_idx_reg;

    logic                    out_valid_reg;
    logic                    out_novel_reg;
    logic                    out_evicted_reg;
    logic [OW-1:0]           out_occ_reg;

    logic                    in_fire;
    logic                    out_fire;
    logic                    slot_free;
    logic                    issue;
    logic                    finish;
    logic                    wr_en;
    logic                    full;
    logic [AW-1:0]           wr_addr;

    logic                    rd_valid;
    logic [AW-1:0]           rd_idx;
    logic [3*COORD_BITS-1:0] rd_coords;
    logic [SW-1:0]           rd_stamp;

    logic                    dist_busy;
    logic                    dist_valid;
    logic [DW-1:0]           dist_sum;
    logic [SW-1:0]           age;
    logic [AW-1:0]           dist_idx;

    knc_pkg::knc_lanes_t     lanes;
    logic [knc_pkg::DIM_W-1:0] dim_eff;
    logic [XW-1:0]           cap_ext;
    logic [XW-1:0]           cap_eff;
    logic [XW-1:0]           count_ext;
    logic [CW+OW-1:0]        occ_wide;
    logic                    take_best;
    logic [knc_pkg::EPS2_W-1:0] eps2_calc;

    // ---------------- handshakes ----------------
    assign in_fire    = point_in.valid & point_in.ready;
    assign out_fire   = out_valid_reg & result_out.ready;
    assign slot_free  = ~out_valid_reg | result_out.ready;

    assign cfg.ready            = 1'b1;
    assign result_out.valid     = out_valid_reg;
    assign result_out.novel     = out_novel_reg;
    assign result_out.evicted   = out_evicted_reg;
    assign result_out.occupancy = out_occ_reg;

    // ---------------- effective settings ----------------
    always_comb
    begin
        dim_eff = (dim_reg == '0) ? knc_pkg::DIM_W'(1) : dim_reg;
        if (dim_eff > knc_pkg::DIM_W'(knc_pkg::MAX_DIM))
            dim_eff = knc_pkg::DIM_W'(knc_pkg::MAX_DIM);
        lanes.use_y = (dim_eff >= knc_pkg::DIM_W'(2));
        lanes.use_z = (dim_eff >= knc_pkg::DIM_W'(3));

        cap_ext = XW'(cap_reg);
        cap_eff = cap_ext;
        if (cap_ext == '0)
            cap_eff = XW'(1);
        else if (cap_ext > XW'(CAPACITY))
            cap_eff = XW'(CAPACITY);
    end

    assign count_ext = XW'(count_reg);
    assign full      = (count_ext >= cap_eff);
    assign eps2_calc = {{knc_pkg::EPS_W{1'b0}}, eps_reg} * {{knc_pkg::EPS_W{1'b0}}, eps_reg};

    // ---------------- sequencer ----------------
    assign issue  = (state_reg == knc_pkg::ST_SCAN) && (scan_idx_reg < count_reg);
    assign finish = (state_reg == knc_pkg::ST_DECIDE) && slot_free;
    assign wr_en  = finish & ~hit_reg;
    assign wr_addr = full ? best_idx_reg : count_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knc_pkg::ST_IDLE:
                if (in_fire)
                    state_next = knc_pkg::ST_SCAN;
            knc_pkg::ST_SCAN:
                if (!issue)
                    state_next = knc_pkg::ST_DRAIN;
            knc_pkg::ST_DRAIN:
                if (!dist_busy)
                    state_next = knc_pkg::ST_DECIDE;
            knc_pkg::ST_DECIDE:
                if (slot_free)
                    state_next = knc_pkg::ST_IDLE;
            default:
                state_next = knc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        point_in.ready = 1'b0;
        unique case (state_reg)
            knc_pkg::ST_IDLE:   point_in.ready = 1'b1;
            knc_pkg::ST_SCAN,
            knc_pkg::ST_DRAIN,
            knc_pkg::ST_DECIDE: point_in.ready = 1'b0;
            default:            point_in.ready = 1'b0;
        endcase
    end

    // evict in place when full: the new center takes the nearest center's slot
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !full)
            count_next = count_reg + CW'(1);
    end

    assign occ_wide = {{OW{1'b0}}, count_next};

    // nearest so far; equal distance goes to the smaller age (newer center)
    assign take_best = !best_valid_reg || (dist_sum < best_dist_reg)
                    || ((dist_sum == best_dist_reg) && (age < best_age_reg));

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= knc_pkg::ST_IDLE;
            dim_reg        <= knc_pkg::DIM_RESET;
            cap_reg        <= knc_pkg::CAP_RESET;
            eps_reg        <= knc_pkg::EPS_RESET;
            count_reg      <= '0;
            ctr_reg        <= '0;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    knc_pkg::CFG_DIMENSION: dim_reg <= cfg.data[knc_pkg::DIM_W-1:0];
                    knc_pkg::CFG_CAPACITY:  cap_reg <= cfg.data[knc_pkg::CAP_W-1:0];
                    knc_pkg::CFG_EPSILON:   eps_reg <= cfg.data[knc_pkg::EPS_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                scan_idx_reg   <= '0;
                hit_reg        <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                if (dist_valid)
                begin
                    if ({{knc_pkg::EPS2_W{1'b0}}, dist_sum} <= CMW'(eps2_reg))
                        hit_reg <= 1'b1;
                    if (take_best)
                        best_valid_reg <= 1'b1;
                end
            end

            count_reg <= count_next;
            if (wr_en)
                ctr_reg <= ctr_reg + SW'(1);

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pt_reg   <= {point_in.coord_z, point_in.coord_y, point_in.coord_x};
            eps2_reg <= eps2_calc;
        end
        if (dist_valid && take_best)
        begin
            best_dist_reg <= dist_sum;
            best_age_reg  <= age;
            best_idx_reg  <= dist_idx;
        end
        if (finish)
        begin
            out_novel_reg   <= ~hit_reg;
            out_evicted_reg <= ~hit_reg & full;
            out_occ_reg     <= occ_wide[OW-1:0];
        end
    end

    // ---------------- datapath ----------------
    knc_store #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (issue),
        .rd_addr   (scan_idx_reg[AW-1:0]),
        .rd_valid  (rd_valid),
        .rd_idx    (rd_idx),
        .rd_coords (rd_coords),
        .rd_stamp  (rd_stamp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_coords (pt_reg),
        .wr_stamp  (ctr_reg)
    );

    knc_dist #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .DW         (DW)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .lanes      (lanes),
        .point      (pt_reg),
        .stamp_now  (ctr_reg),
        .in_valid   (rd_valid),
        .in_idx     (rd_idx),
        .in_coords  (rd_coords),
        .in_stamp   (rd_stamp),
        .busy       (dist_busy),
        .dist_valid (dist_valid),
        .dist_sum   (dist_sum),
        .age        (age),
        .idx        (dist_idx)
    );

    // ---------------- assertions ----------------
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == knc_pkg::ST_IDLE) |-> !dist_busy)
        else $error("distance pipeline active while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMW'(count_reg) <= CMW'(CAPACITY))
        else $error("occupancy above capacity");

    a_evict_novel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_novel_reg) |-> !out_evicted_reg)
        else $error("eviction reported for a known point");

    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert without eviction did not grow occupancy");

endmodule
`default_nettype wire
